// ===== sv/fqd_pkg.sv =====
`default_nettype none
package fqd_pkg;

  // Operation codes carried in the kind field of a request.
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_DELETE  = 2'd2;

  // Result status codes.
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned COUNT_W  = 5;

  typedef struct packed {
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  typedef struct packed {
    logic                status;
    logic [HANDLE_W-1:0] out_handle;
    logic [COUNT_W-1:0]  count;
  } rsp_t;

endpackage
`default_nettype wire

// ===== sv/fifo_queue_with_delete_unit.sv =====
// FIFO queue of nonzero handles with delete of the first matching handle.
// A request on req (kind, handle) is taken when req_valid is high and
// req_stall is low; each request yields exactly one response on rsp
// (status, out_handle, count), taken when rsp_valid is high and rsp_stall
// is low. The handles live in a single-port-write, registered-read memory
// used as a circular buffer, so every operation is a short read-modify-write
// sequence and one request is worked on at a time.
// An enqueue, and any request rejected at once (null handle, empty or full
// queue, unused kind), goes straight to its response; a dequeue first reads
// the front entry, and a delete walks the queue up to the fill level, at
// most DEPTH entries; the delete walk reads one entry per cycle to compare it
// and then moves each later entry down one slot on the same memory port.
// Results land in an output register, so a new request is taken while the
// previous response is still held by a stalled receiver; a finished result
// then waits inside the unit until the output register frees up.
// Reset (synchronous, active high) empties the queue at once; no clearing
// pass runs, since only entries below the fill level are ever read.
`default_nettype none
module fifo_queue_with_delete_unit #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire fqd_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output fqd_pkg::rsp_t      rsp
);

  logic          busy;
  logic          res_valid;
  fqd_pkg::rsp_t res;
  logic          res_take;

  fqd_core #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // The core only accepts a new request while idle.
  assign req_stall = busy;

  // The output register loads when it is empty or being emptied this cycle.
  assign res_take = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fqd_core.sv =====
`default_nettype none
module fqd_core #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  input  wire fqd_pkg::req_t req,
  output logic               busy,
  output logic               res_valid,
  output fqd_pkg::rsp_t      res,
  input  wire logic          res_take
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_SUM = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DEQ   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state;

  // Circular buffer: entry at head is the front of the queue.
  logic [HANDLE_BITS-1:0] mem [DEPTH];
  logic [HANDLE_BITS-1:0] rd_data;
  logic [AW-1:0]          rd_addr;
  logic                   we;
  logic [AW-1:0]          wa;
  logic [HANDLE_BITS-1:0] wd;

  logic [AW-1:0] head;
  logic [CW-1:0] occ;

  // Delete walk: addr holds the entry whose data is in rd_data, pos its rank.
  logic [HANDLE_BITS-1:0] op_h;
  logic [AW-1:0]          addr;
  logic [AW-1:0]          wr_addr;
  logic [CW-1:0]          pos;
  logic                   res_status;
  logic [fqd_pkg::HANDLE_W-1:0] res_handle;

  logic [HANDLE_BITS+fqd_pkg::HANDLE_W-1:0] req_h_wide;
  logic [HANDLE_BITS-1:0]                   req_h;
  logic [HANDLE_BITS+fqd_pkg::HANDLE_W-1:0] rd_wide;
  logic [CW+fqd_pkg::COUNT_W-1:0]           occ_wide;

  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] addr_inc;
  logic [CW-1:0] pos_inc;
  logic          more;
  logic          enq_ok;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    wrap_inc = (a == LAST_ADDR) ? '0 : a + AW'(1);
  endfunction

  // Handles are cut or zero-extended to the stored width.
  assign req_h_wide = {{HANDLE_BITS{1'b0}}, req.handle};
  assign req_h      = req_h_wide[HANDLE_BITS-1:0];
  assign rd_wide    = {{fqd_pkg::HANDLE_W{1'b0}}, rd_data};
  assign occ_wide   = {{fqd_pkg::COUNT_W{1'b0}}, occ};

  assign tail_sum = {1'b0, head} + {1'b0, occ[AW-1:0]};
  assign tail     = (tail_sum >= DEPTH_SUM) ? AW'(tail_sum - DEPTH_SUM) : tail_sum[AW-1:0];
  assign head_inc = wrap_inc(head);
  assign addr_inc = wrap_inc(addr);
  assign pos_inc  = pos + CW'(1);
  assign more     = (pos_inc < occ);
  assign enq_ok   = (req_h != '0) && (occ != DEPTH_CNT);

  always_comb begin
    we      = 1'b0;
    wa      = tail;
    wd      = req_h;
    rd_addr = head;
    case (state)
      S_IDLE: begin
        if (req_valid && (req.kind == fqd_pkg::OP_ENQUEUE) && enq_ok) begin
          we = 1'b1;
        end
      end
      S_SCAN: begin
        rd_addr = addr_inc;
      end
      S_SHIFT: begin
        rd_addr = addr_inc;
        we      = 1'b1;
        wa      = wr_addr;
        wd      = rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      occ   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_h       <= req_h;
            addr       <= head;
            pos        <= '0;
            res_status <= fqd_pkg::ST_REJECT;
            res_handle <= '0;
            state      <= S_RESP;
            case (req.kind)
              fqd_pkg::OP_ENQUEUE: begin
                if (enq_ok) begin
                  occ        <= occ + CW'(1);
                  res_status <= fqd_pkg::ST_OK;
                end
              end
              fqd_pkg::OP_DEQUEUE: begin
                if (occ != '0) begin
                  state <= S_DEQ;
                end
              end
              fqd_pkg::OP_DELETE: begin
                if ((req_h != '0) && (occ != '0)) begin
                  state <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_DEQ: begin
          res_handle <= rd_wide[fqd_pkg::HANDLE_W-1:0];
          res_status <= fqd_pkg::ST_OK;
          head       <= head_inc;
          occ        <= occ - CW'(1);
          state      <= S_RESP;
        end
        S_SCAN: begin
          if (rd_data == op_h) begin
            if (more) begin
              wr_addr <= addr;
              addr    <= addr_inc;
              pos     <= pos_inc;
              state   <= S_SHIFT;
            end else begin
              occ        <= occ - CW'(1);
              res_status <= fqd_pkg::ST_OK;
              state      <= S_RESP;
            end
          end else if (more) begin
            addr <= addr_inc;
            pos  <= pos_inc;
          end else begin
            state <= S_RESP;
          end
        end
        S_SHIFT: begin
          wr_addr <= addr;
          if (more) begin
            addr <= addr_inc;
            pos  <= pos_inc;
          end else begin
            occ        <= occ - CW'(1);
            res_status <= fqd_pkg::ST_OK;
            state      <= S_RESP;
          end
        end
        S_RESP: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state != S_IDLE);
  assign res_valid      = (state == S_RESP);
  assign res.status     = res_status;
  assign res.out_handle = res_handle;
  assign res.count      = occ_wide[fqd_pkg::COUNT_W-1:0];

endmodule
`default_nettype wire

// ===== sim/tb_fifo_queue_with_delete_unit.sv =====
`timescale 1ns / 1ps
module tb_fifo_queue_with_delete_unit;

  // Kind 3 has no operation behind it; the unit must reject it and change nothing.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned RANDOM_REQUESTS = 650;
  // The slowest delete walks the whole queue, and a stalled receiver or an
  // idle sender can add more per request. This limit is many times the worst
  // case for the whole run.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Cycles to keep watching after the last expected response has arrived.
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned MAX_REPORTS = 10;

  // One line of the directed table. A line may repeat its request, with the
  // handle counting up by one on each repeat. Where "fixed" is set, the typed
  // response is the expectation; otherwise the queue model supplies it.
  typedef struct packed {
    logic [1:0]                   kind;
    logic [fqd_pkg::HANDLE_W-1:0] handle;
    logic [4:0]                   reps;
    logic                         fixed;
    fqd_pkg::rsp_t                want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  fqd_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  fqd_pkg::rsp_t rsp;

  // Side information that travels with the request on the request channel so
  // the acceptance monitor knows whether a typed response applies.
  logic req_fixed = 1'b0;
  fqd_pkg::rsp_t req_want = '0;

  // Set while the run is in its stretch with no idling on either side.
  bit calm = 1'b0;

  // Queue model: its own copy of the stored handles and the fill level.
  logic [fqd_pkg::HANDLE_W-1:0] model_slots[QUEUE_DEPTH];
  int unsigned model_fill = 0;

  // Responses expected from the unit, oldest first.
  fqd_pkg::rsp_t pending_rsp_q[$];
  table_row_t directed_rows[$];
  logic [fqd_pkg::HANDLE_W-1:0] handle_pool[16];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  fifo_queue_with_delete_unit #(
    .DEPTH(QUEUE_DEPTH),
    .HANDLE_BITS(fqd_pkg::HANDLE_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  // Close the gap left at position pos by moving every later handle down.
  function automatic void drop_slot(int unsigned pos);
    for (int unsigned i = pos; i + 1 < model_fill; i++) begin
      model_slots[i] = model_slots[i + 1];
    end
    model_fill--;
  endfunction

  // Apply one request to the queue model and return the response it owes.
  function automatic fqd_pkg::rsp_t apply_queue_op(fqd_pkg::req_t r);
    fqd_pkg::rsp_t res;
    int hit;
    res.status = fqd_pkg::ST_REJECT;
    res.out_handle = '0;
    hit = -1;
    case (r.kind)
      fqd_pkg::OP_ENQUEUE: begin
        if (r.handle != '0 && model_fill < QUEUE_DEPTH) begin
          model_slots[model_fill] = r.handle;
          model_fill++;
          res.status = fqd_pkg::ST_OK;
        end
      end
      fqd_pkg::OP_DEQUEUE: begin
        if (model_fill > 0) begin
          res.out_handle = model_slots[0];
          drop_slot(0);
          res.status = fqd_pkg::ST_OK;
        end
      end
      fqd_pkg::OP_DELETE: begin
        // Only the first match from the front goes; later duplicates stay.
        if (r.handle != '0) begin
          for (int unsigned i = 0; i < model_fill; i++) begin
            if (hit < 0 && model_slots[i] == r.handle) begin
              hit = i;
            end
          end
          if (hit >= 0) begin
            drop_slot(hit);
            res.status = fqd_pkg::ST_OK;
          end
        end
      end
      default: begin
      end
    endcase
    res.count = model_fill[fqd_pkg::COUNT_W-1:0];
    return res;
  endfunction

  function automatic void add_row(logic [1:0] kind, logic [fqd_pkg::HANDLE_W-1:0] handle,
                                  logic [4:0] reps, logic fixed, logic status,
                                  logic [fqd_pkg::HANDLE_W-1:0] out_handle,
                                  logic [fqd_pkg::COUNT_W-1:0] count);
    table_row_t row;
    row.kind = kind;
    row.handle = handle;
    row.reps = reps;
    row.fixed = fixed;
    row.want.status = status;
    row.want.out_handle = out_handle;
    row.want.count = count;
    directed_rows.push_back(row);
  endfunction

  // Offer one request, with a random idle gap in front of it unless the run
  // is calm, and hold it steady until the unit accepts it. Every assignment
  // here lands on a rising edge, and the edge that ends the task never sees
  // a second assignment to req_valid.
  task automatic send_request(fqd_pkg::req_t r, logic fixed, fqd_pkg::rsp_t want);
    while (!calm && $urandom_range(99) < 13) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    req_fixed <= fixed;
    req_want <= want;
    @(posedge clk);
    while (req_stall) begin
      @(posedge clk);
    end
  endtask

  // Receiver side: stall at random, except during the calm stretch.
  always @(posedge clk) begin
    if (rst || calm) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < 13);
    end
  end

  // Acceptance and checking share one block so that a request accepted on an
  // edge has its expectation queued before any response on that edge is read.
  always @(posedge clk) begin
    fqd_pkg::rsp_t expect_rsp;
    fqd_pkg::rsp_t got_rsp;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        expect_rsp = apply_queue_op(req);
        if (req_fixed) begin
          expect_rsp = req_want;
        end
        pending_rsp_q.push_back(expect_rsp);
      end
      if (rsp_valid && !rsp_stall) begin
        got_rsp = rsp;
        if (pending_rsp_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("ERROR: response with no request waiting: status %0b handle %h count %0d",
                     got_rsp.status, got_rsp.out_handle, got_rsp.count);
          end
        end else begin
          expect_rsp = pending_rsp_q.pop_front();
          if (got_rsp.status !== expect_rsp.status ||
              got_rsp.out_handle !== expect_rsp.out_handle ||
              got_rsp.count !== expect_rsp.count) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("ERROR: status %0b/%0b handle %h/%h count %0d/%0d (expected/actual)",
                       expect_rsp.status, got_rsp.status,
                       expect_rsp.out_handle, got_rsp.out_handle,
                       expect_rsp.count, got_rsp.count);
            end
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    fqd_pkg::req_t r;
    fqd_pkg::rsp_t none;
    int unsigned roll;
    int unsigned enq_share;
    int unsigned drain_wait;
    none = '0;

    // Pool of nonzero handles shared by enqueues and deletes, so that deletes
    // find matches often and duplicates show up in the queue.
    foreach (handle_pool[i]) begin
      handle_pool[i] = $urandom;
      while (handle_pool[i] == '0) begin
        handle_pool[i] = $urandom;
      end
    end

    // Directed part: rejections on an empty queue, null handles, the unused
    // kind, extreme handle values, delete of the first of two equal handles,
    // a full queue, and deletes at the middle and the back.
    add_row(fqd_pkg::OP_DEQUEUE, '0, 1, 1, fqd_pkg::ST_REJECT, '0, 0);
    add_row(fqd_pkg::OP_DELETE, 32'h0000_0005, 1, 1, fqd_pkg::ST_REJECT, '0, 0);
    add_row(fqd_pkg::OP_ENQUEUE, '0, 1, 1, fqd_pkg::ST_REJECT, '0, 0);
    add_row(OP_UNUSED, 32'hFFFF_FFFF, 1, 1, fqd_pkg::ST_REJECT, '0, 0);
    add_row(fqd_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 1, 1, fqd_pkg::ST_OK, '0, 1);
    add_row(fqd_pkg::OP_ENQUEUE, 32'h0000_0001, 1, 1, fqd_pkg::ST_OK, '0, 2);
    add_row(fqd_pkg::OP_DELETE, '0, 1, 1, fqd_pkg::ST_REJECT, '0, 2);
    add_row(fqd_pkg::OP_DELETE, 32'h1234_5678, 1, 1, fqd_pkg::ST_REJECT, '0, 2);
    add_row(fqd_pkg::OP_DEQUEUE, '0, 1, 1, fqd_pkg::ST_OK, 32'hFFFF_FFFF, 1);
    add_row(fqd_pkg::OP_ENQUEUE, 32'h8000_0000, 1, 0, fqd_pkg::ST_OK, '0, 0);
    add_row(fqd_pkg::OP_ENQUEUE, 32'h0000_0001, 1, 0, fqd_pkg::ST_OK, '0, 0);
    add_row(fqd_pkg::OP_DELETE, 32'h0000_0001, 1, 0, fqd_pkg::ST_OK, '0, 0);
    add_row(fqd_pkg::OP_ENQUEUE, 32'hA000_0000, 14, 0, fqd_pkg::ST_OK, '0, 0);
    add_row(fqd_pkg::OP_ENQUEUE, 32'h5555_5555, 1, 1, fqd_pkg::ST_REJECT, '0, 16);
    add_row(fqd_pkg::OP_DELETE, 32'hA000_0006, 1, 0, fqd_pkg::ST_OK, '0, 0);
    add_row(fqd_pkg::OP_DELETE, 32'h0000_0001, 1, 0, fqd_pkg::ST_OK, '0, 0);
    add_row(fqd_pkg::OP_DELETE, 32'hA000_000D, 1, 0, fqd_pkg::ST_OK, '0, 0);
    add_row(fqd_pkg::OP_DEQUEUE, '0, 1, 0, fqd_pkg::ST_OK, '0, 0);
    add_row(fqd_pkg::OP_ENQUEUE, 32'hAAAA_AAAA, 1, 0, fqd_pkg::ST_OK, '0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      for (int unsigned k = 0; k < directed_rows[i].reps; k++) begin
        r.kind = directed_rows[i].kind;
        r.handle = directed_rows[i].handle + k;
        send_request(r, directed_rows[i].fixed, directed_rows[i].want);
      end
    end

    // Random part. Phases of forty requests alternate between filling the
    // queue (mostly enqueues) and draining it (mostly dequeues and deletes),
    // so the queue swings between empty and full many times. A small share
    // of requests is noise: null handles, the unused kind, stray handles.
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      calm = (n >= 250 && n < 400);
      if ($urandom_range(99) < 8) begin
        r.kind = 2'($urandom_range(3));
        r.handle = $urandom_range(1) ? '0 : $urandom;
      end else begin
        enq_share = ((n / 40) % 2 == 0) ? 65 : 20;
        roll = $urandom_range(99);
        if (roll < enq_share) begin
          r.kind = fqd_pkg::OP_ENQUEUE;
          r.handle = ($urandom_range(9) == 0) ? $urandom
                                              : handle_pool[4'($urandom_range(15))];
        end else if (roll < enq_share + (100 - enq_share) / 2) begin
          r.kind = fqd_pkg::OP_DEQUEUE;
          r.handle = $urandom;
        end else begin
          r.kind = fqd_pkg::OP_DELETE;
          r.handle = ($urandom_range(9) == 0) ? $urandom
                                              : handle_pool[4'($urandom_range(15))];
        end
      end
      send_request(r, 1'b0, none);
    end
    req_valid <= 1'b0;
    calm = 1'b0;
    // One more edge so the last accepted request has its expectation queued.
    @(posedge clk);

    // Wait for every outstanding response, then watch a little longer for
    // any response the unit should not produce.
    while (pending_rsp_q.size() != 0) begin
      @(posedge clk);
    end
    drain_wait = DRAIN_CYCLES;
    repeat (drain_wait) @(posedge clk);

    if (error_count == 0 && pending_rsp_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
